### src/bipc_pkg.sv
// Shared types, constants and reset values of the backlight idle power controller.
package bipc_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int NOW_BITS       = 32;
  localparam int LEVEL_BITS     = 8;
  localparam int PCT_BITS       = 7;
  localparam int FADE_BITS      = 16;
  localparam int OP_BITS        = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int PROD_BITS      = LEVEL_BITS + FADE_BITS;
  localparam int QUO_BITS       = LEVEL_BITS;

  localparam logic [31:0]           IDLE_DIM_RST      = 32'd30000;
  localparam logic [31:0]           IDLE_SLEEP_RST    = 32'd120000;
  localparam logic [LEVEL_BITS-1:0] DIM_LEVEL_RST     = 8'd32;
  localparam logic [PCT_BITS-1:0]   LOW_PCT_RST       = 7'd20;
  localparam logic [PCT_BITS-1:0]   CRIT_PCT_RST      = 7'd5;
  localparam logic [FADE_BITS-1:0]  DIM_FADE_RST      = 16'd500;
  localparam logic [FADE_BITS-1:0]  RESTORE_FADE_RST  = 16'd200;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL        = 8'd255;

  typedef enum logic [OP_BITS-1:0] {
    OP_POLL     = 3'd0,
    OP_ACTIVITY = 3'd1,
    OP_BATTERY  = 3'd2,
    OP_SET      = 3'd3,
    OP_FADE     = 3'd4
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IDLE_DIM     = 3'd0,
    REG_IDLE_SLEEP   = 3'd1,
    REG_DIM_LEVEL    = 3'd2,
    REG_LOW_PCT      = 3'd3,
    REG_CRIT_PCT     = 3'd4,
    REG_SLEEP_BLOCK  = 3'd5,
    REG_DIM_FADE     = 3'd6,
    REG_RESTORE_FADE = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    opcode;
    logic [NOW_BITS-1:0]   now_ms;
    logic [PCT_BITS-1:0]   battery_percent;
    logic                  charging;
    logic [LEVEL_BITS-1:0] new_level;
    logic [FADE_BITS-1:0]  fade_length_ms;
  } item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### src/bipc_if.sv
// Request and result channel interfaces of the backlight idle power controller.
interface bipc_in_if;
  logic                            valid;
  logic                            ready;
  logic [bipc_pkg::OP_BITS-1:0]    opcode;
  logic [bipc_pkg::NOW_BITS-1:0]   now_ms;
  logic [bipc_pkg::PCT_BITS-1:0]   battery_percent;
  logic                            charging;
  logic [bipc_pkg::LEVEL_BITS-1:0] new_level;
  logic [bipc_pkg::FADE_BITS-1:0]  fade_length_ms;

  modport source (
    output valid, opcode, now_ms, battery_percent, charging, new_level, fade_length_ms,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, battery_percent, charging, new_level, fade_length_ms,
    output ready
  );
endinterface

interface bipc_out_if;
  logic                            valid;
  logic                            ready;
  logic [bipc_pkg::LEVEL_BITS-1:0] light_level;
  logic                            dimmed;
  logic                            sleep_request;
  logic                            battery_low;
  logic                            battery_critical;

  modport source (
    output valid, light_level, dimmed, sleep_request, battery_low, battery_critical,
    input  ready
  );
  modport sink (
    input  valid, light_level, dimmed, sleep_request, battery_low, battery_critical,
    output ready
  );
endinterface

### src/backlight_idle_power_controller_top.sv
// Top level of the backlight idle power controller.
//
//   Channel   Direction  Handshake        Contents
//   item      in         valid / ready    opcode, now_ms, battery and level fields
//   result    out        valid / ready    light_level, dimmed, sleep and battery flags
//   cfg       in         cfg_wr_en only   cfg_index selects the register, cfg_data
//
// A request is latched on acceptance, evaluated in EVAL and committed to the result
// register in FINISH; a poll that lands inside a running fade also passes through
// MUL, DSTART and DIV, where the one-bit-per-cycle divider works out the fade fraction over twenty-four steps.
// One request is in work at a time, so a new one is taken only once the last is committed;
// the result register lets it in while the previous result still waits.
// Synchronous reset restores register defaults; a stalled result holds the request.
module backlight_idle_power_controller_top #(
  parameter int TIME_BITS = bipc_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  bipc_in_if.sink                              item,
  bipc_out_if.source                           result,
  input  logic                                 cfg_wr_en,
  input  logic [bipc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bipc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  bipc_pkg::item_t   item_req;
  bipc_pkg::cmd_t    cmd;
  bipc_pkg::status_t status;
  logic              in_ready;

  // Bundle the request payload for the datapath latch.
  assign item_req.opcode          = item.opcode;
  assign item_req.now_ms          = item.now_ms;
  assign item_req.battery_percent = item.battery_percent;
  assign item_req.charging        = item.charging;
  assign item_req.new_level       = item.new_level;
  assign item_req.fade_length_ms  = item.fade_length_ms;
  assign item.ready               = in_ready;

  // Sequence each request: latch, evaluate, optionally multiply and divide, commit.
  bipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the configuration and backlight state; drive the result register.
  bipc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_req  (item_req),
    .cmd       (cmd),
    .status    (status),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

### src/bipc_div.sv
// Restoring divider, one quotient bit per cycle, for the fade fraction.
module bipc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bipc_pkg::PROD_BITS-1:0]    dividend,
  input  logic [bipc_pkg::FADE_BITS-1:0]    divisor,
  output logic                              done,
  output logic [bipc_pkg::QUO_BITS-1:0]     quotient
);

  localparam int PB       = bipc_pkg::PROD_BITS;
  localparam int FB       = bipc_pkg::FADE_BITS;
  localparam int CNT_BITS = $clog2(PB);

  logic [PB-1:0]       dq;
  logic [FB-1:0]       rem;
  logic [FB-1:0]       dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [FB:0]         rem_sh;
  logic [FB:0]         rem_dif;
  logic                fits;

  assign rem_sh  = {rem, dq[PB-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_dif = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_BITS'(PB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_dif[FB-1:0] : rem_sh[FB-1:0];
      dq  <= {dq[PB-2:0], fits};
    end
  end

  assign quotient = dq[bipc_pkg::QUO_BITS-1:0];

endmodule

### src/bipc_datapath.sv
// Datapath: configuration, backlight state, fade arithmetic and result register.
module bipc_datapath #(
  parameter int TIME_BITS = bipc_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bipc_pkg::item_t                      item_req,
  input  bipc_pkg::cmd_t                       cmd,
  output bipc_pkg::status_t                    status,
  input  logic                                 cfg_wr_en,
  input  logic [bipc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bipc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  bipc_out_if.source                           result
);

  localparam int LB       = bipc_pkg::LEVEL_BITS;
  localparam int PB       = bipc_pkg::PCT_BITS;
  localparam int FB       = bipc_pkg::FADE_BITS;
  localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Configuration
  logic [31:0]   idle_dim_ms;
  logic [31:0]   idle_sleep_ms;
  logic [LB-1:0] dim_level;
  logic [PB-1:0] low_percent;
  logic [PB-1:0] critical_percent;
  logic          sleep_block;
  logic [FB-1:0] dim_fade_ms;
  logic [FB-1:0] restore_fade_ms;

  // Backlight state
  logic [LB-1:0]        current_level, current_level_next;
  logic [LB-1:0]        target_level, target_level_next;
  logic [LB-1:0]        saved_level, saved_level_next;
  logic [LB-1:0]        fade_origin, fade_origin_next;
  logic [FB-1:0]        fade_span, fade_span_next;
  logic [TIME_BITS-1:0] fade_began, fade_began_next;
  logic [TIME_BITS-1:0] last_active, last_active_next;
  logic                 dim_flag, dim_flag_next;
  logic                 low_flag, low_flag_next;
  logic                 critical_flag, critical_flag_next;
  logic                 sleep_req;

  // Latched request
  bipc_pkg::op_t        op;
  logic [TIME_BITS-1:0] now_t;
  logic [PB-1:0]        pct;
  logic                 chg;
  logic [LB-1:0]        lvl;
  logic [FB-1:0]        flen;

  logic [bipc_pkg::PROD_BITS-1:0] product;
  logic [bipc_pkg::QUO_BITS-1:0]  quotient;
  logic                           div_done;

  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] idle;
  logic                 fade_run;
  logic                 fade_end;
  logic                 fade_rise;
  logic [LB-1:0]        fade_delta;
  logic [LB-1:0]        fade_step;
  logic [LB-1:0]        level_adv;
  logic [FB-1:0]        span_adv;
  logic                 over_sleep;
  logic                 over_dim;
  logic                 out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_dim_ms      <= bipc_pkg::IDLE_DIM_RST;
      idle_sleep_ms    <= bipc_pkg::IDLE_SLEEP_RST;
      dim_level        <= bipc_pkg::DIM_LEVEL_RST;
      low_percent      <= bipc_pkg::LOW_PCT_RST;
      critical_percent <= bipc_pkg::CRIT_PCT_RST;
      sleep_block      <= 1'b0;
      dim_fade_ms      <= bipc_pkg::DIM_FADE_RST;
      restore_fade_ms  <= bipc_pkg::RESTORE_FADE_RST;
    end else if (cfg_wr_en) begin
      unique case (bipc_pkg::reg_index_t'(cfg_index))
        bipc_pkg::REG_IDLE_DIM:     idle_dim_ms      <= cfg_data;
        bipc_pkg::REG_IDLE_SLEEP:   idle_sleep_ms    <= cfg_data;
        bipc_pkg::REG_DIM_LEVEL:    dim_level        <= cfg_data[LB-1:0];
        bipc_pkg::REG_LOW_PCT:      low_percent      <= cfg_data[PB-1:0];
        bipc_pkg::REG_CRIT_PCT:     critical_percent <= cfg_data[PB-1:0];
        bipc_pkg::REG_SLEEP_BLOCK:  sleep_block      <= cfg_data[0];
        bipc_pkg::REG_DIM_FADE:     dim_fade_ms      <= cfg_data[FB-1:0];
        bipc_pkg::REG_RESTORE_FADE: restore_fade_ms  <= cfg_data[FB-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= bipc_pkg::op_t'(item_req.opcode);
      now_t <= TIME_BITS'(item_req.now_ms);
      pct   <= item_req.battery_percent;
      chg   <= item_req.charging;
      lvl   <= item_req.new_level;
      flen  <= item_req.fade_length_ms;
    end
  end

  assign elapsed    = now_t - fade_began;
  assign idle       = now_t - last_active;
  assign fade_run   = (fade_span != '0) && (current_level != target_level);
  assign fade_end   = elapsed >= TIME_BITS'(fade_span);
  assign fade_rise  = target_level >= fade_origin;
  assign fade_delta = fade_rise ? (target_level - fade_origin) : (fade_origin - target_level);
  assign fade_step  = fade_rise ? (fade_origin + quotient) : (fade_origin - quotient);
  assign over_sleep = CMP_BITS'(idle) > CMP_BITS'(idle_sleep_ms);
  assign over_dim   = CMP_BITS'(idle) > CMP_BITS'(idle_dim_ms);

  // Elapsed time is below the span here, so its low bits carry it whole.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product <= bipc_pkg::PROD_BITS'(fade_delta) *
                 bipc_pkg::PROD_BITS'(elapsed[FB-1:0]);
    end
  end

  bipc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (fade_span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    level_adv = current_level;
    span_adv  = fade_span;
    if (op == bipc_pkg::OP_POLL && fade_run) begin
      if (fade_end) begin
        level_adv = target_level;
        span_adv  = '0;
      end else begin
        level_adv = fade_step;
      end
    end
  end

  always_comb begin
    current_level_next = level_adv;
    target_level_next  = target_level;
    saved_level_next   = saved_level;
    fade_origin_next   = fade_origin;
    fade_span_next     = span_adv;
    fade_began_next    = fade_began;
    last_active_next   = last_active;
    dim_flag_next      = dim_flag;
    low_flag_next      = low_flag;
    critical_flag_next = critical_flag;
    sleep_req          = 1'b0;
    unique case (op)
      bipc_pkg::OP_POLL: begin
        if (!sleep_block) begin
          if (over_sleep) begin
            sleep_req = 1'b1;
          end else if (over_dim && !dim_flag) begin
            saved_level_next  = level_adv;
            target_level_next = dim_level;
            fade_origin_next  = level_adv;
            fade_span_next    = dim_fade_ms;
            fade_began_next   = now_t;
            dim_flag_next     = 1'b1;
          end
        end
      end
      bipc_pkg::OP_ACTIVITY: begin
        last_active_next = now_t;
        if (dim_flag) begin
          target_level_next = saved_level;
          fade_origin_next  = current_level;
          fade_span_next    = restore_fade_ms;
          fade_began_next   = now_t;
          dim_flag_next     = 1'b0;
        end
      end
      bipc_pkg::OP_BATTERY: begin
        low_flag_next      = pct <= low_percent;
        critical_flag_next = pct <= critical_percent;
        sleep_req          = (pct <= critical_percent) && !chg && !sleep_block;
      end
      bipc_pkg::OP_SET: begin
        current_level_next = lvl;
        target_level_next  = lvl;
        saved_level_next   = lvl;
        fade_span_next     = '0;
      end
      bipc_pkg::OP_FADE: begin
        target_level_next = lvl;
        fade_origin_next  = current_level;
        fade_span_next    = flen;
        fade_began_next   = now_t;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= bipc_pkg::LEVEL_FULL;
      target_level  <= bipc_pkg::LEVEL_FULL;
      saved_level   <= bipc_pkg::LEVEL_FULL;
      fade_origin   <= '0;
      fade_span     <= '0;
      fade_began    <= '0;
      last_active   <= '0;
      dim_flag      <= 1'b0;
      low_flag      <= 1'b0;
      critical_flag <= 1'b0;
    end else if (cmd.commit) begin
      current_level <= current_level_next;
      target_level  <= target_level_next;
      saved_level   <= saved_level_next;
      fade_origin   <= fade_origin_next;
      fade_span     <= fade_span_next;
      fade_began    <= fade_began_next;
      last_active   <= last_active_next;
      dim_flag      <= dim_flag_next;
      low_flag      <= low_flag_next;
      critical_flag <= critical_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.light_level      <= sleep_req ? '0 : current_level_next;
      result.dimmed           <= dim_flag_next;
      result.sleep_request    <= sleep_req;
      result.battery_low      <= low_flag_next;
      result.battery_critical <= critical_flag_next;
    end
  end

  assign result.valid     = out_valid;
  assign status.needs_div = (op == bipc_pkg::OP_POLL) && fade_run && !fade_end;
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid || result.ready;

endmodule

### src/bipc_ctrl.sv
// Controller state machine sequencing each request through the datapath.
module bipc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bipc_pkg::status_t status,
  output bipc_pkg::cmd_t    cmd
);

  bipc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bipc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bipc_pkg::ST_IDLE:   if (in_valid) state_next = bipc_pkg::ST_EVAL;
      bipc_pkg::ST_EVAL:   state_next = status.needs_div ? bipc_pkg::ST_MUL
                                                         : bipc_pkg::ST_FINISH;
      bipc_pkg::ST_MUL:    state_next = bipc_pkg::ST_DSTART;
      bipc_pkg::ST_DSTART: state_next = bipc_pkg::ST_DIV;
      bipc_pkg::ST_DIV:    if (status.div_done) state_next = bipc_pkg::ST_FINISH;
      bipc_pkg::ST_FINISH: if (status.out_free) state_next = bipc_pkg::ST_IDLE;
      default:             state_next = bipc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state == bipc_pkg::ST_IDLE;
    cmd.load      = (state == bipc_pkg::ST_IDLE) && in_valid;
    cmd.mul       = state == bipc_pkg::ST_MUL;
    cmd.div_start = state == bipc_pkg::ST_DSTART;
    cmd.commit    = (state == bipc_pkg::ST_FINISH) && status.out_free;
  end

endmodule
